// ===== hw/rtl/tvi_pkg.sv =====
// Shared types and constants for the trilinear vector interpolator.
// No dependencies; every other file except tvi_lerp refers to it by scoped names.
package tvi_pkg;

  // Width of the u, v, w weight fields on the request channel.
  localparam int IN_BITS = 16;

  // Corner register file.
  localparam int NUM_CORNERS     = 8;
  localparam int CORNER_SEL_BITS = 3;
  localparam int CFG_INDEX_BITS  = 4;

  // Register index map; the digits give the (u, v, w) corner.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CORNER_000 = 4'd0,
    CORNER_100 = 4'd1,
    CORNER_010 = 4'd2,
    CORNER_110 = 4'd3,
    CORNER_001 = 4'd4,
    CORNER_101 = 4'd5,
    CORNER_011 = 4'd6,
    CORNER_111 = 4'd7
  } corner_idx_t;

endpackage

// ===== hw/rtl/tvi_ifs.sv =====
// Channel interfaces: request point, result point and register write port.
// Depends on tvi_pkg for field widths.

interface tvi_in_if;
  logic                         valid;
  logic                         ready;
  logic [tvi_pkg::IN_BITS-1:0]  u;
  logic [tvi_pkg::IN_BITS-1:0]  v;
  logic [tvi_pkg::IN_BITS-1:0]  w;

  modport source (output valid, output u, output v, output w, input ready);
  modport sink   (input valid, input u, input v, input w, output ready);
endinterface

interface tvi_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;
  logic signed [COORD_BITS-1:0] z;

  modport source (output valid, output x, output y, output z, input ready);
  modport sink   (input valid, input x, input y, input z, output ready);
endinterface

interface tvi_cfg_if #(
  parameter int DATA_BITS = 48
);
  logic                                valid;
  logic                                ready;
  logic [tvi_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [DATA_BITS-1:0]                data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tvi_lerp.sv =====
// Two-stage rounded lerp on offset-binary coordinates:
// y = (a*2^F + (b-a)*t + 2^(F-1)) >> F, with t in 0..2^F. Stand-alone.
module tvi_lerp #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] a,
  input  logic [COORD_BITS-1:0] b,
  input  logic [FRAC_BITS:0]    t,
  output logic [COORD_BITS-1:0] y
);

  localparam int WB = FRAC_BITS + 1;
  localparam int PW = COORD_BITS + WB + 2;
  localparam int SW = COORD_BITS + FRAC_BITS + 2;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic signed [COORD_BITS:0] diff;
  logic signed [WB:0]         t_s;
  logic signed [PW-1:0]       prod_full;
  logic signed [SW-1:0]       prod;
  logic [COORD_BITS-1:0]      a_d;
  logic signed [SW-1:0]       sum;

  // Multiply stage: |b-a| * t stays below 2^(C+F), so SW bits hold it.
  always_comb begin
    diff      = $signed({1'b0, b}) - $signed({1'b0, a});
    t_s       = $signed({1'b0, t});
    prod_full = PW'(diff) * PW'(t_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_full[SW-1:0];
      a_d  <= a;
    end
  end

  // Add and round stage; the sum is non-negative and below 2^(C+F).
  always_comb begin
    sum = $signed({2'b00, a_d, {FRAC_BITS{1'b0}}}) + prod + $signed(HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= sum[FRAC_BITS +: COORD_BITS];
    end
  end

endmodule

// ===== hw/rtl/trilinear_vector_interpolator_top.sv =====
// Trilinear vector interpolator: eight corner registers blended by (u, v, w).
// Pipeline from request accept to result valid: one weight-clamp
// stage, then a multiply and an add/round stage for each of the u, v, w lerps.
// Throughput one request per cycle; the whole pipeline holds while the
// result register is stalled. Synchronous active-high reset clears the
// valid bits and the corner registers. Depends on tvi_pkg, tvi_ifs, tvi_lerp.
module trilinear_vector_interpolator_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic      clk,
  input  logic      rst,
  tvi_in_if.sink    in,
  tvi_out_if.source out,
  tvi_cfg_if.sink   cfg
);

  localparam int NSTG = 7;
  localparam int WB   = FRAC_BITS + 1;
  localparam int IB   = tvi_pkg::IN_BITS;
  localparam int TB   = (IB > WB) ? IB : WB;
  localparam int RB   = 3 * COORD_BITS;
  localparam logic [TB-1:0]         ONE_T = TB'(1) << FRAC_BITS;
  localparam logic [COORD_BITS-1:0] OFF   = COORD_BITS'(1) << (COORD_BITS - 1);

  logic [RB-1:0]   corner [tvi_pkg::NUM_CORNERS];
  logic [NSTG-1:0] vld;
  logic            en;

  // ---------------------------------------------------------------------
  // Corner registers
  // ---------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++) begin
        corner[i] <= '0;
      end
    end else if (cfg.valid && cfg.index <= tvi_pkg::CORNER_111) begin
      corner[cfg.index[tvi_pkg::CORNER_SEL_BITS-1:0]] <= cfg.data;
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: advance every stage together unless the result stalls
  // ---------------------------------------------------------------------
  assign en       = !vld[NSTG-1] || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: clamp weights to one
  // ---------------------------------------------------------------------
  logic [TB-1:0] u_ext, v_ext, w_ext;
  logic [WB-1:0] tu_next, tv_next, tw_next;
  logic [WB-1:0] tu0, tv0, tw0;
  logic [WB-1:0] tv1, tv2, tw1, tw2, tw3, tw4;

  always_comb begin
    u_ext   = TB'(in.u);
    v_ext   = TB'(in.v);
    w_ext   = TB'(in.w);
    tu_next = (u_ext > ONE_T) ? ONE_T[WB-1:0] : u_ext[WB-1:0];
    tv_next = (v_ext > ONE_T) ? ONE_T[WB-1:0] : v_ext[WB-1:0];
    tw_next = (w_ext > ONE_T) ? ONE_T[WB-1:0] : w_ext[WB-1:0];
  end

  // Carry the v and w weights alongside the lerp stages that need them.
  always_ff @(posedge clk) begin
    if (en) begin
      tu0 <= tu_next;
      tv0 <= tv_next;
      tw0 <= tw_next;
      tv1 <= tv0;
      tv2 <= tv1;
      tw1 <= tw0;
      tw2 <= tw1;
      tw3 <= tw2;
      tw4 <= tw3;
    end
  end

  // ---------------------------------------------------------------------
  // Lerp lanes, one per coordinate
  // ---------------------------------------------------------------------
  logic [COORD_BITS-1:0] cu [3][4];
  logic [COORD_BITS-1:0] cv [3][2];
  logic [COORD_BITS-1:0] cw [3];

  for (genvar k = 0; k < 3; k++) begin : g_coord
    for (genvar j = 0; j < 4; j++) begin : g_u
      tvi_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp (
        .clk (clk),
        .en  (en),
        .a   (corner[2*j][k*COORD_BITS +: COORD_BITS] ^ OFF),
        .b   (corner[2*j+1][k*COORD_BITS +: COORD_BITS] ^ OFF),
        .t   (tu0),
        .y   (cu[k][j])
      );
    end

    for (genvar j = 0; j < 2; j++) begin : g_v
      tvi_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp (
        .clk (clk),
        .en  (en),
        .a   (cu[k][2*j]),
        .b   (cu[k][2*j+1]),
        .t   (tv2),
        .y   (cv[k][j])
      );
    end

    tvi_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp_w (
      .clk (clk),
      .en  (en),
      .a   (cv[k][0]),
      .b   (cv[k][1]),
      .t   (tw4),
      .y   (cw[k])
    );
  end

  // Back from offset binary to two's complement.
  assign out.valid = vld[NSTG-1];
  assign out.x     = $signed(cw[0] ^ OFF);
  assign out.y     = $signed(cw[1] ^ OFF);
  assign out.z     = $signed(cw[2] ^ OFF);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> vld[0])
    else $error("accepted request did not enter stage 0");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |-> !in.ready)
    else $error("input taken while result stalled");

  a_valid_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> (out.valid == $past(vld[NSTG-2])))
    else $error("valid bit lost or invented at result stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for trilinear_vector_interpolator_top: drives points and corner writes,
// predicts each blended point in-line and checks results in order.
// Depends on tvi_pkg, tvi_ifs and the interpolator RTL.
module testbench;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 15;
  localparam int CORNER_BITS = 3 * COORD_BITS;
  localparam int PIPE_CYCLES = 7;
  localparam int MAX_REPORTS = 10;
  localparam logic [63:0] ONE_W  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_W = 64'd1 << (FRAC_BITS - 1);
  localparam logic [15:0] W_ONE  = 16'd32768;
  localparam logic [15:0] C_MAX  = 16'h7fff;
  localparam logic [15:0] C_MIN  = 16'h8000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  logic clk;
  logic rst;

  tvi_in_if                            in_ch();
  tvi_out_if #(.COORD_BITS(COORD_BITS)) out_ch();
  tvi_cfg_if #(.DATA_BITS(CORNER_BITS)) cfg_ch();

  trilinear_vector_interpolator_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in (in_ch),
    .out(out_ch),
    .cfg(cfg_ch)
  );

  logic [CORNER_BITS-1:0] corner_regs [tvi_pkg::NUM_CORNERS];
  point_t                 expected_points [$];
  int                     mismatch_count;
  bit                     src_idle;
  bit                     sink_idle;
  bit                     hold_active;
  int                     sink_wait;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.u = '0;
    in_ch.v = '0;
    in_ch.w = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatch_count = 0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_active = 1'b0;
    sink_wait = 0;
    for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++) corner_regs[i] = '0;
  end

  // Offset-binary rounded lerp: a*(1-t) + b*t, halves up.
  function automatic logic [63:0] lerp_q(logic [63:0] a, logic [63:0] b, logic [63:0] t);
    return (a * (ONE_W - t) + b * t + HALF_W) >> FRAC_BITS;
  endfunction

  function automatic point_t blend_point(logic [15:0] pu, logic [15:0] pv, logic [15:0] pw);
    logic [63:0] tu, tv, tw;
    logic [63:0] c [tvi_pkg::NUM_CORNERS];
    logic [63:0] c00, c10, c01, c11, c0, c1, cc;
    logic [COORD_BITS-1:0] res [3];
    point_t p;
    tu = (pu > ONE_W) ? ONE_W : 64'(pu);
    tv = (pv > ONE_W) ? ONE_W : 64'(pv);
    tw = (pw > ONE_W) ? ONE_W : 64'(pw);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++)
        c[i] = 64'(corner_regs[i][k*COORD_BITS +: COORD_BITS] ^ C_MIN);
      c00 = lerp_q(c[0], c[1], tu);
      c10 = lerp_q(c[2], c[3], tu);
      c01 = lerp_q(c[4], c[5], tu);
      c11 = lerp_q(c[6], c[7], tu);
      c0  = lerp_q(c00, c10, tv);
      c1  = lerp_q(c01, c11, tv);
      cc  = lerp_q(c0, c1, tw);
      res[k] = cc[COORD_BITS-1:0] ^ C_MIN;
    end
    p.x = res[0];
    p.y = res[1];
    p.z = res[2];
    return p;
  endfunction

  function automatic logic [CORNER_BITS-1:0] pack_corner(logic [15:0] cx, logic [15:0] cy,
                                                         logic [15:0] cz);
    return {cz, cy, cx};
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return W_ONE;
      2: return 16'($urandom_range(32769, 65535));
      3: return 16'($urandom_range(0, 3));
      4: return 16'($urandom_range(32764, 32768));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic write_reg(input logic [tvi_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [CORNER_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < tvi_pkg::NUM_CORNERS)
      corner_regs[idx[tvi_pkg::CORNER_SEL_BITS-1:0]] = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_point(input logic [15:0] pu, input logic [15:0] pv,
                            input logic [15:0] pw);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.u <= pu;
    in_ch.v <= pv;
    in_ch.w <= pw;
    do @(posedge clk); while (!in_ch.ready);
    expected_points.push_back(blend_point(pu, pv, pw));
  endtask

  // Drop the request and hold until every result is back.
  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 3) @(posedge clk);
  endtask

  // Sink pacing: reload the stall count on each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      sink_wait = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      sink_wait = sink_idle ? $urandom_range(0, 11) : 0;
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && !hold_active && (sink_wait == 0);
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.x;
      got.y = out_ch.y;
      got.z = out_ch.z;
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     want.x, want.y, want.z, got.x, got.y, got.z);
        end
      end
    end
  end

  task automatic test_reset_state();
    send_point(16'd0, 16'd0, 16'd0);
    send_point(W_ONE, W_ONE, W_ONE);
    send_point(16'hffff, 16'd0, 16'd12345);
    drain_pipeline();
  endtask

  task automatic test_extremes();
    logic [15:0] wts [8];
    wts = '{16'd0, W_ONE, 16'd16384, 16'd1, 16'd32767, 16'd32769, 16'hffff, 16'd16385};
    // x follows u, y follows v, z follows w, each swinging full scale.
    for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++)
      write_reg(tvi_pkg::corner_idx_t'(i),
                pack_corner(i[0] ? C_MAX : C_MIN, i[1] ? C_MAX : C_MIN,
                            i[2] ? C_MAX : C_MIN));
    for (int j = 0; j < 8; j++) send_point(wts[j], wts[(j + 3) % 8], wts[(j + 5) % 8]);
    drain_pipeline();
    for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++)
      write_reg(tvi_pkg::corner_idx_t'(i),
                pack_corner((i[0] ^ i[1] ^ i[2]) ? C_MIN : C_MAX, C_MAX,
                            (i % 2) ? 16'd0 : C_MIN));
    for (int j = 0; j < 6; j++) send_point(wts[j], wts[7 - j], wts[(j + 2) % 8]);
    drain_pipeline();
  endtask

  task automatic test_unknown_index();
    for (int idx = tvi_pkg::NUM_CORNERS; idx < (1 << tvi_pkg::CFG_INDEX_BITS); idx++)
      write_reg(idx[tvi_pkg::CFG_INDEX_BITS-1:0], CORNER_BITS'({$urandom, $urandom}));
    send_point(16'd8192, 16'd24576, 16'd4096);
    send_point(W_ONE, 16'd0, 16'd16384);
    send_point(16'd100, 16'd32700, W_ONE);
    drain_pipeline();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 12; phase++) begin
      src_idle  = phase[0];
      sink_idle = phase[1];
      for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++)
        write_reg(tvi_pkg::corner_idx_t'(i),
                  pack_corner(rand_coord(), rand_coord(), rand_coord()));
      repeat (120) send_point(rand_weight(), rand_weight(), rand_weight());
      drain_pipeline();
    end
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    for (int i = 0; i < tvi_pkg::NUM_CORNERS; i++)
      write_reg(tvi_pkg::corner_idx_t'(i),
                pack_corner(rand_coord(), rand_coord(), rand_coord()));
    fork
      begin
        @(posedge clk);
        hold_active = 1'b1;
        repeat (400) @(posedge clk);
        hold_active = 1'b0;
      end
      repeat (150) send_point(rand_weight(), rand_weight(), rand_weight());
    join
    drain_pipeline();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_reset_state();
    test_extremes();
    test_unknown_index();
    test_random_phases();
    test_backpressure();
    if (expected_points.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("trilinear_vector_interpolator_top regression: pass");
    end else begin
      $display("trilinear_vector_interpolator_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("trilinear_vector_interpolator_top regression: fail");
    $finish;
  end

endmodule
